FILE: design/jrc_pkg.sv
`timescale 1ns / 1ps

package jrc_pkg;

    // register indexes on the configuration port
    localparam logic CFG_SCHEMA = 1'b0;
    localparam logic CFG_SIZE   = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int SIZE_W     = 13;
    localparam int COUNT_W    = 13;

    // default bound on the payload size register
    localparam int MAX_PAYLOAD_DEF = 4096;

    localparam logic [31:0]        MAGIC_WORD  = 32'h3152_4A54;
    localparam logic [31:0]        CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0]        CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] HDR_BYTES   = 13'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 13'h1FFF;

    typedef struct packed {
        logic        record_ok;
        logic [31:0] payload_crc;
    } jrc_result_t;

    // reflected crc-32, one byte, eight shift steps
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            v = (v >> 1) ^ (CRC_POLY & {32{v[0]}});
        end
        return v;
    endfunction

endpackage

FILE: design/jrc_core.sv
`timescale 1ns / 1ps

module jrc_core #(
    parameter int MAX_PAYLOAD = jrc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    input  logic [31:0]                 expected_schema,
    input  logic [jrc_pkg::SIZE_W-1:0]  payload_size,
    output jrc_pkg::jrc_result_t        result
);
    import jrc_pkg::*;

    localparam logic [16:0] PAYLOAD_LIMIT = 17'(MAX_PAYLOAD);

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [31:0]        crc_reg, crc_next;
    logic [31:0]        header_word_reg, header_word_next;
    logic               header_good_reg, header_good_next;
    logic [31:0]        stored_crc_reg, stored_crc_next;

    logic [COUNT_W-1:0] count_inc;
    logic [31:0]        word_upd;
    logic [31:0]        crc_upd;
    logic               good_upd;
    logic [31:0]        stored_upd;
    logic               in_header;

    assign in_header = (byte_count_reg < HDR_BYTES);
    assign count_inc = (byte_count_reg == COUNT_MAX) ? COUNT_MAX
                                                     : byte_count_reg + 13'd1;

    // header word assembly, little-endian, one lane per byte; payload bytes update the crc
    always_comb
    begin
        word_upd   = header_word_reg;
        good_upd   = header_good_reg;
        stored_upd = stored_crc_reg;
        crc_upd    = crc_reg;
        if (in_header)
        begin
            unique case (byte_count_reg[1:0])
                2'd0: word_upd = {24'd0, data_byte};
                2'd1: word_upd = {header_word_reg[31:16], data_byte, header_word_reg[7:0]};
                2'd2: word_upd = {header_word_reg[31:24], data_byte, header_word_reg[15:0]};
                2'd3: word_upd = {data_byte, header_word_reg[23:0]};
                default: word_upd = header_word_reg;
            endcase
            if (byte_count_reg == 13'd3 && word_upd != MAGIC_WORD)
                good_upd = 1'b0;
            if (byte_count_reg == 13'd7 && word_upd != expected_schema)
                good_upd = 1'b0;
            if (byte_count_reg == 13'd11 && word_upd != {19'd0, payload_size})
                good_upd = 1'b0;
            if (byte_count_reg == 13'd15)
                stored_upd = word_upd;
        end
        else
        begin
            crc_upd = crc_byte(crc_reg, data_byte);
        end
    end

    // final checks on the last beat
    always_comb
    begin
        result.payload_crc = ~crc_upd;
        result.record_ok   = good_upd
            && ({4'd0, payload_size} <= PAYLOAD_LIMIT)
            && ({1'b0, count_inc} == ({1'b0, payload_size} + {1'b0, HDR_BYTES}))
            && (stored_upd == ~crc_upd);
    end

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        crc_next         = crc_reg;
        header_word_next = header_word_reg;
        header_good_next = header_good_reg;
        stored_crc_next  = stored_crc_reg;
        if (step)
        begin
            if (last_byte)
            begin
                byte_count_next  = '0;
                crc_next         = CRC_INIT;
                header_word_next = '0;
                header_good_next = 1'b1;
                stored_crc_next  = '0;
            end
            else
            begin
                byte_count_next  = count_inc;
                crc_next         = crc_upd;
                header_word_next = word_upd;
                header_good_next = good_upd;
                stored_crc_next  = stored_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            crc_reg         <= CRC_INIT;
            header_word_reg <= '0;
            header_good_reg <= 1'b1;
            stored_crc_reg  <= '0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            crc_reg         <= crc_next;
            header_word_reg <= header_word_next;
            header_good_reg <= header_good_next;
            stored_crc_reg  <= stored_crc_next;
        end
    end

endmodule

FILE: design/journal_record_checker.sv
`timescale 1ns / 1ps
// path from an accepted input beat to its result beat: input register, then record state update and result
// register; one result per record, on the last byte
// throughput: one byte per cycle; the crc byte update is unrolled in a single cycle
// only a last byte waits while an unread result sits in the output register
// reset: rst_n asynchronous active low; clears the record state, both pipeline valids,
// and sets expected_schema to 0 and payload_size to 1
module journal_record_checker #(
    parameter int MAX_PAYLOAD = jrc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // last_byte
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // [0] record_ok, [32:1] payload_crc, rest zero
    // configuration writes
    input  logic                          cfg_we,
    input  logic [jrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jrc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import jrc_pkg::*;

    // configuration registers
    logic [31:0]       schema_reg;
    logic [SIZE_W-1:0] size_reg;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    jrc_result_t out_res_reg;
    jrc_result_t core_res;

    logic out_free;
    logic step;
    logic take_in;

    // the output register can take a new result this cycle
    assign out_free = !out_valid_reg || m_tready;
    // a non-last byte produces no result and never waits on the output side
    assign step     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || step;
    assign take_in  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            schema_reg <= '0;
            size_reg   <= 13'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCHEMA: schema_reg <= cfg_data;
                CFG_SIZE:   size_reg   <= cfg_data[SIZE_W-1:0];
                default:    schema_reg <= schema_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step && in_last_reg)
            out_res_reg <= core_res;
    end

    // record state: header words, running crc, byte count
    jrc_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .data_byte       (in_byte_reg),
        .last_byte       (in_last_reg),
        .expected_schema (schema_reg),
        .payload_size    (size_reg),
        .result          (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.payload_crc, out_res_reg.record_ok};

endmodule
